FILE: src/lprm_pkg.sv
package lprm_pkg;

    // widths fixed by the request and result fields
    localparam int INDEX_W = 4;
    localparam int ADDR_W  = 32;

    // slots that an index field can name
    localparam int INDEX_SLOTS = 2 ** INDEX_W;

    // action codes carried on the input channel
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

    typedef enum logic {
        CMD_WRITE,
        CMD_LOOKUP
    } cmd_kind_t;

    // one classified command; key is the destination for a write, the address for a lookup
    typedef struct packed {
        cmd_kind_t          kind;
        logic [INDEX_W-1:0] index;
        logic [ADDR_W-1:0]  key;
        logic [ADDR_W-1:0]  mask;
        logic               valid;
    } cmd_t;

    // one stored route
    typedef struct packed {
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] mask;
    } route_t;

endpackage

FILE: src/lprm_front.sv
module lprm_front #(
    parameter int LIVE_ENTRIES = 16
) (
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          action,
    input  logic [lprm_pkg::INDEX_W-1:0]  entry_index,
    input  logic [lprm_pkg::ADDR_W-1:0]   entry_dest,
    input  logic [lprm_pkg::ADDR_W-1:0]   entry_mask,
    input  logic                          entry_valid,
    input  logic [lprm_pkg::ADDR_W-1:0]   lookup_addr,
    input  logic                          q_full,
    output logic                          q_push,
    output lprm_pkg::cmd_t                q_push_cmd
);

    logic is_lookup;
    logic in_range;

    // classify the request; writes to a missing slot are taken and dropped
    assign is_lookup = (action == lprm_pkg::ACT_LOOKUP);
    assign in_range  = (int'(entry_index) < LIVE_ENTRIES);

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full && (is_lookup || in_range);

    // build the command for the back end
    always_comb
    begin
        q_push_cmd.kind  = is_lookup ? lprm_pkg::CMD_LOOKUP : lprm_pkg::CMD_WRITE;
        q_push_cmd.index = entry_index;
        q_push_cmd.key   = is_lookup ? lookup_addr : entry_dest;
        q_push_cmd.mask  = entry_mask;
        q_push_cmd.valid = entry_valid;
    end

endmodule

FILE: src/lprm_queue.sv
module lprm_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lprm_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output lprm_pkg::cmd_t  pop_cmd
);

    lprm_pkg::cmd_t                      slot_reg [lprm_pkg::QUEUE_DEPTH];
    logic [lprm_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg;
    logic [lprm_pkg::QUEUE_PTR_W-1:0]    wr_ptr_next;
    logic [lprm_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg;
    logic [lprm_pkg::QUEUE_PTR_W-1:0]    rd_ptr_next;
    logic [lprm_pkg::QUEUE_CNT_W-1:0]    count_reg;
    logic [lprm_pkg::QUEUE_CNT_W-1:0]    count_next;

    assign full      = (count_reg == lprm_pkg::QUEUE_CNT_W'(lprm_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: src/lprm_back.sv
module lprm_back #(
    parameter int LIVE_ENTRIES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  lprm_pkg::cmd_t                q_cmd,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic [lprm_pkg::INDEX_W-1:0]  match_index,
    output logic [lprm_pkg::ADDR_W-1:0]   match_mask
);

    localparam int IDX_W = (LIVE_ENTRIES > 1) ? $clog2(LIVE_ENTRIES) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_DONE
    } state_t;

    // route memory, one read or one write per cycle
    lprm_pkg::route_t               route_mem [LIVE_ENTRIES];
    lprm_pkg::route_t               rd_data_reg;

    state_t                         state_reg;
    state_t                         state_next;
    logic [IDX_W-1:0]               scan_idx_reg;
    logic [IDX_W-1:0]               scan_idx_next;
    logic                           rd_pend_reg;
    logic                           rd_pend_next;
    logic [IDX_W-1:0]               rd_idx_reg;
    logic [IDX_W-1:0]               rd_idx_next;
    logic [lprm_pkg::ADDR_W-1:0]    addr_reg;
    logic [lprm_pkg::ADDR_W-1:0]    addr_next;
    logic                           found_reg;
    logic                           found_next;
    logic [IDX_W-1:0]               best_idx_reg;
    logic [IDX_W-1:0]               best_idx_next;
    logic [lprm_pkg::ADDR_W-1:0]    best_mask_reg;
    logic [lprm_pkg::ADDR_W-1:0]    best_mask_next;
    logic [LIVE_ENTRIES-1:0]        valid_bits_reg;
    logic [LIVE_ENTRIES-1:0]        valid_bits_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           out_hit_reg;
    logic                           out_hit_next;
    logic [lprm_pkg::INDEX_W-1:0]   out_index_reg;
    logic [lprm_pkg::INDEX_W-1:0]   out_index_next;
    logic [lprm_pkg::ADDR_W-1:0]    out_mask_reg;
    logic [lprm_pkg::ADDR_W-1:0]    out_mask_next;

    logic                           entry_match;
    logic                           take;
    logic                           found_cmp;
    logic [IDX_W-1:0]               idx_cmp;
    logic [lprm_pkg::ADDR_W-1:0]    mask_cmp;
    logic                           out_free;
    logic                           mem_we;
    logic [IDX_W-1:0]               mem_widx;

    // compare the entry read last cycle against the lookup address
    assign entry_match = rd_pend_reg && valid_bits_reg[rd_idx_reg]
                         && (((addr_reg ^ rd_data_reg.dest) & rd_data_reg.mask) == '0);
    assign take      = entry_match && (!found_reg || (rd_data_reg.mask > best_mask_reg));
    assign found_cmp = found_reg || take;
    assign idx_cmp   = take ? rd_idx_reg : best_idx_reg;
    assign mask_cmp  = take ? rd_data_reg.mask : best_mask_reg;

    assign out_free = !out_valid_reg || !out_stall;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign mem_we   = q_pop && (q_cmd.kind == lprm_pkg::CMD_WRITE);
    assign mem_widx = q_cmd.index[IDX_W-1:0];

    // sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        rd_pend_next    = (state_reg == ST_SCAN);
        rd_idx_next     = scan_idx_reg;
        addr_next       = addr_reg;
        found_next      = found_cmp;
        best_idx_next   = idx_cmp;
        best_mask_next  = mask_cmp;
        valid_bits_next = valid_bits_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_hit_next    = out_hit_reg;
        out_index_next  = out_index_reg;
        out_mask_next   = out_mask_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_cmd.kind == lprm_pkg::CMD_LOOKUP)
                    begin
                        addr_next      = q_cmd.key;
                        scan_idx_next  = '0;
                        found_next     = 1'b0;
                        best_idx_next  = '0;
                        best_mask_next = '0;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        valid_bits_next[mem_widx] = q_cmd.valid;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == IDX_W'(LIVE_ENTRIES - 1))
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_LAST:
            begin
                // last entry is being compared; send straight out if the slot is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = found_cmp;
                    out_index_next = lprm_pkg::INDEX_W'(idx_cmp);
                    out_mask_next  = mask_cmp;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = found_reg;
                    out_index_next = lprm_pkg::INDEX_W'(best_idx_reg);
                    out_mask_next  = best_mask_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer state and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_idx_reg   <= '0;
            rd_pend_reg    <= 1'b0;
            rd_idx_reg     <= '0;
            addr_reg       <= '0;
            found_reg      <= 1'b0;
            best_idx_reg   <= '0;
            best_mask_reg  <= '0;
            valid_bits_reg <= '0;
            out_valid_reg  <= 1'b0;
            out_hit_reg    <= 1'b0;
            out_index_reg  <= '0;
            out_mask_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_idx_reg   <= scan_idx_next;
            rd_pend_reg    <= rd_pend_next;
            rd_idx_reg     <= rd_idx_next;
            addr_reg       <= addr_next;
            found_reg      <= found_next;
            best_idx_reg   <= best_idx_next;
            best_mask_reg  <= best_mask_next;
            valid_bits_reg <= valid_bits_next;
            out_valid_reg  <= out_valid_next;
            out_hit_reg    <= out_hit_next;
            out_index_reg  <= out_index_next;
            out_mask_reg   <= out_mask_next;
        end
    end

    // route memory write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            route_mem[mem_widx] <= '{dest: q_cmd.key, mask: q_cmd.mask};
        end
        if (state_reg == ST_SCAN)
        begin
            rd_data_reg <= route_mem[scan_idx_reg];
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = out_hit_reg;
    assign match_index = out_index_reg;
    assign match_mask  = out_mask_reg;

endmodule

FILE: src/longest_prefix_route_match_top.sv
// a lookup scans min(ROUTE_ENTRIES, 16) route slots, reading one slot per cycle through the single port
//   of the route memory; the back end pops a new command only while idle, so one lookup finishes
//   before the next command is taken
// write requests are applied by the back end while idle and give no result
// reset clears all route valid bits, empties the command queue and the result register;
//   stored destinations and masks are not cleared
module longest_prefix_route_match_top #(
    parameter int ROUTE_ENTRIES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          action,
    input  logic [lprm_pkg::INDEX_W-1:0]  entry_index,
    input  logic [lprm_pkg::ADDR_W-1:0]   entry_dest,
    input  logic [lprm_pkg::ADDR_W-1:0]   entry_mask,
    input  logic                          entry_valid,
    input  logic [lprm_pkg::ADDR_W-1:0]   lookup_addr,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic [lprm_pkg::INDEX_W-1:0]  match_index,
    output logic [lprm_pkg::ADDR_W-1:0]   match_mask
);

    // only slots an index field can name are ever written
    localparam int LIVE_ENTRIES = (ROUTE_ENTRIES < lprm_pkg::INDEX_SLOTS)
                                  ? ROUTE_ENTRIES : lprm_pkg::INDEX_SLOTS;

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_valid;
    lprm_pkg::cmd_t q_push_cmd;
    lprm_pkg::cmd_t q_pop_cmd;

    // request intake and classification
    lprm_front #(
        .LIVE_ENTRIES (LIVE_ENTRIES)
    ) u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .entry_index (entry_index),
        .entry_dest  (entry_dest),
        .entry_mask  (entry_mask),
        .entry_valid (entry_valid),
        .lookup_addr (lookup_addr),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_cmd  (q_push_cmd)
    );

    // command queue
    lprm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_cmd   (q_pop_cmd)
    );

    // table update and lookup scan
    lprm_back #(
        .LIVE_ENTRIES (LIVE_ENTRIES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_cmd       (q_pop_cmd),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hit         (hit),
        .match_index (match_index),
        .match_mask  (match_mask)
    );

    // queue is never pushed while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("command queue pushed while full");

    // back end pops only what is there
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("command queue popped while empty");

    // a miss reports index and mask as zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (match_index == '0 && match_mask == '0))
        else $error("miss result carries nonzero index or mask");

    // a push that is not taken in the same cycle leaves the queue non-empty
    a_push_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_pop) |=> q_valid)
        else $error("pushed command lost");

endmodule
